// ----- rtl/m3i_pkg.sv -----
// Shared constants for the 3x3 matrix inverse core.
package m3i_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int ELEM_WIDTH_DEF = 32;
  localparam int NUM_ELEMS      = 9;

  // tuser bit positions on the result side
  localparam int USER_W         = 2;
  localparam int USER_SINGULAR  = 0;
  localparam int USER_SATURATED = 1;

endpackage

// ----- rtl/matrix3_inverse_core.sv -----
// 3x3 matrix inverse by adjugate over determinant, pipelined, one matrix per cycle.
//
//  channel  | dir | tdata (low bit first)                       | tuser
//  ---------+-----+---------------------------------------------+----------------------
//  s_axis   | in  | col1_x col1_y col1_z col2_x .. col3_z       | -
//  m_axis   | out | inv1_x inv1_y inv1_z inv2_x .. inv3_z       | singular, saturated
//
// A matrix can be taken in every cycle unless the result queue is full. The path to the
// result queue has seven arithmetic stages for the products, cofactors, determinant and
// magnitudes, then one restoring-division stage per quotient bit shared by all nine
// elements, then saturation. The pipeline moves as a whole; a two entry result queue
// lets it keep taking matrices while one result waits, and it holds only when that
// queue is full. rst clears valid bits and the queue.
module matrix3_inverse_core #(
  parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF,
  parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // col1_x, col1_y, col1_z, col2_x, col2_y, col2_z, col3_x, col3_y, col3_z
  input  logic [((m3i_pkg::NUM_ELEMS*ELEM_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // inv1_x, inv1_y, inv1_z, inv2_x, inv2_y, inv2_z, inv3_x, inv3_y, inv3_z
  output logic [((m3i_pkg::NUM_ELEMS*ELEM_WIDTH+7)/8)*8-1:0] m_tdata,
  // singular, saturated
  output logic [m3i_pkg::USER_W-1:0] m_tuser
);
  import m3i_pkg::*;

  localparam int E   = ELEM_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int N   = NUM_ELEMS;
  localparam int TDW = ((N*E+7)/8)*8;
  localparam int CW  = 2*E + 1;         // cofactor
  localparam int DW  = 3*E + 1;         // determinant
  localparam int NW  = 2*E + 2*F;       // numerator magnitude
  localparam int RW  = (NW > 4*E) ? NW : 4*E;
  localparam int NS  = E + 8;           // pipeline stages

  localparam logic [E-1:0] QMAX = {1'b0, {(E-1){1'b1}}};
  localparam logic [E-1:0] QMIN = {1'b1, {(E-1){1'b0}}};

  logic          en;
  logic [NS-1:0] v;
  logic [1:0]    cnt;

  assign en       = (cnt != 2'd2);
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NS-2:0], s_tvalid};
    end
  end

  // stage 0: element products
  logic signed [E-1:0]   a   [N];
  logic signed [2*E-1:0] p_a [N];
  logic signed [2*E-1:0] p_b [N];
  logic signed [E-1:0]   a1  [3];

  for (genvar i = 0; i < N; i++) begin : g_unpack
    assign a[i] = $signed(s_tdata[i*E +: E]);
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      localparam int R1 = (r + 1) % 3;
      localparam int R2 = (r + 2) % 3;
      localparam int C1 = (c + 1) % 3;
      localparam int C2 = (c + 2) % 3;
      always_ff @(posedge clk) begin
        if (en) begin
          p_a[r*3+c] <= a[C1*3+R1] * a[C2*3+R2];
          p_b[r*3+c] <= a[C2*3+R1] * a[C1*3+R2];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        a1[c] <= a[c*3];
      end
    end
  end

  // stage 1: cofactors
  logic signed [CW-1:0] cof1 [N];
  logic signed [E-1:0]  a2   [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        cof1[k] <= $signed({p_a[k][2*E-1], p_a[k]}) - $signed({p_b[k][2*E-1], p_b[k]});
      end
      a2 <= a1;
    end
  end

  // stage 2: determinant partial products, cofactor split in low and high halves
  logic signed [2*E:0]  dlo  [3];
  logic signed [2*E:0]  dhi  [3];
  logic signed [CW-1:0] cof2 [N];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        dlo[c] <= a2[c] * $signed({1'b0, cof1[c][E-1:0]});
        dhi[c] <= a2[c] * $signed(cof1[c][CW-1:E]);
      end
      cof2 <= cof1;
    end
  end

  // stage 3: determinant terms
  logic signed [DW-1:0] trm  [3];
  logic signed [CW-1:0] cof3 [N];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        trm[c] <= ($signed({{E{dhi[c][2*E]}}, dhi[c]}) <<< E)
                + $signed({{E{dlo[c][2*E]}}, dlo[c]});
      end
      cof3 <= cof2;
    end
  end

  // stage 4: determinant
  logic signed [DW-1:0] det;
  logic signed [CW-1:0] cof4 [N];

  always_ff @(posedge clk) begin
    if (en) begin
      det  <= trm[0] + trm[1] + trm[2];
      cof4 <= cof3;
    end
  end

  // stage 5: magnitudes and signs
  logic [DW-1:0]  dabs;
  logic [CW-1:0]  cabs [N];
  logic           sing5;
  logic           dneg5;
  logic [3*E-1:0] dmag5;
  logic [NW-1:0]  nmag5 [N];
  logic [N-1:0]   nneg5;

  always_comb begin
    dabs = det[DW-1] ? DW'(-det) : DW'(det);
    for (int k = 0; k < N; k++) begin
      cabs[k] = cof4[k][CW-1] ? CW'(-cof4[k]) : CW'(cof4[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sing5 <= (det == '0);
      dneg5 <= det[DW-1];
      dmag5 <= dabs[3*E-1:0];
      for (int k = 0; k < N; k++) begin
        nmag5[k] <= {cabs[k][2*E-1:0], {(2*F){1'b0}}};
        nneg5[k] <= cof4[k][CW-1];
      end
    end
  end

  // stage 6 fills index 0; division stage j fills index j+1
  logic [RW-1:0]  drm [E+1][N];
  logic [E-1:0]   dq  [E+1][N];
  logic [3*E-1:0] dd  [E+1];
  logic           dsg [E+1];
  logic           ddn [E+1];
  logic [N-1:0]   dnn [E+1];
  logic [N-1:0]   dbg [E+1];

  // a quotient of 2^E or more saturates whatever its sign
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        drm[0][k] <= RW'(nmag5[k]);
        dq[0][k]  <= '0;
        dbg[0][k] <= RW'(nmag5[k]) >= (RW'(dmag5) << E);
      end
      dd[0]  <= dmag5;
      dsg[0] <= sing5;
      ddn[0] <= dneg5;
      dnn[0] <= nneg5;
    end
  end

  for (genvar j = 0; j < E; j++) begin : g_div
    localparam int B = E - 1 - j;
    logic [RW-1:0] ds;
    logic [N-1:0]  ge;
    logic [RW-1:0] rem_next [N];
    logic [E-1:0]  q_next   [N];

    always_comb begin
      ds = RW'(dd[j]) << B;
      for (int k = 0; k < N; k++) begin
        ge[k]       = (drm[j][k] >= ds);
        rem_next[k] = ge[k] ? drm[j][k] - ds : drm[j][k];
        q_next[k]   = dq[j][k];
        q_next[k][B] = ge[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < N; k++) begin
          drm[j+1][k] <= rem_next[k];
          dq[j+1][k]  <= q_next[k];
        end
        dd[j+1]  <= dd[j];
        dsg[j+1] <= dsg[j];
        ddn[j+1] <= ddn[j];
        dnn[j+1] <= dnn[j];
        dbg[j+1] <= dbg[j];
      end
    end
  end

  // final stage: zero singular results, apply sign, clip
  logic [N*E-1:0] res;
  logic [N-1:0]   clip;
  logic           qneg;
  logic [N*E-1:0] fin_data;
  logic           fin_sing;
  logic           fin_sat;

  always_comb begin
    res  = '0;
    clip = '0;
    qneg = 1'b0;
    for (int k = 0; k < N; k++) begin
      qneg = dnn[E][k] ^ ddn[E];
      priority if (dsg[E]) begin
        res[k*E +: E] = '0;
      end else if (dbg[E][k]) begin
        clip[k]       = 1'b1;
        res[k*E +: E] = qneg ? QMIN : QMAX;
      end else if (qneg) begin
        if ({1'b0, dq[E][k]} > {1'b0, QMIN}) begin
          clip[k]       = 1'b1;
          res[k*E +: E] = QMIN;
        end else begin
          res[k*E +: E] = E'(-dq[E][k]);
        end
      end else if (dq[E][k][E-1]) begin
        clip[k]       = 1'b1;
        res[k*E +: E] = QMAX;
      end else begin
        res[k*E +: E] = dq[E][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_data <= res;
      fin_sing <= dsg[E];
      fin_sat  <= |clip;
    end
  end

  // result queue, two entries
  logic [TDW-1:0]    ob_data [2];
  logic [USER_W-1:0] ob_user [2];
  logic              wp;
  logic              rp;
  logic              push;
  logic              pop;
  logic [USER_W-1:0] fin_user;

  assign push = en && v[NS-1];
  assign pop  = m_tvalid && m_tready;

  always_comb begin
    fin_user                 = '0;
    fin_user[USER_SINGULAR]  = fin_sing;
    fin_user[USER_SATURATED] = fin_sat;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ob_data[wp] <= TDW'(fin_data);
      ob_user[wp] <= fin_user;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      unique case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = ob_data[rp];
  assign m_tuser  = ob_user[rp];

endmodule

// ----- tb/matrix3_inverse_core_tb.sv -----
// Self-checking testbench for the pipelined 3x3 matrix inverse core.
`timescale 1ns / 1ps

class inverse_scoreboard;
  localparam int EW = 32;
  localparam int FB = 16;
  localparam int DW = m3i_pkg::NUM_ELEMS * EW;

  typedef struct packed {
    logic [DW-1:0] data;
    logic [m3i_pkg::USER_W-1:0] user;
  } inverse_t;

  inverse_t pending[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  // Compute the adjugate over the determinant exactly, then truncate and clip.
  function inverse_t compute_inverse(logic [DW-1:0] mat);
    logic signed [EW-1:0] a[3][3];
    logic signed [255:0] cof[3][3];
    logic signed [255:0] det, num, dmag, nmag, quo;
    logic signed [255:0] lim_hi, lim_lo, res;
    inverse_t r;
    bit sat;
    int rr, cc;
    sat = 0;
    r = '0;
    for (cc = 0; cc < 3; cc++)
      for (rr = 0; rr < 3; rr++)
        a[rr][cc] = mat[(cc*3+rr)*EW +: EW];
    for (rr = 0; rr < 3; rr++)
      for (cc = 0; cc < 3; cc++) begin
        cof[rr][cc] = 256'(a[(rr+1)%3][(cc+1)%3]) * 256'(a[(rr+2)%3][(cc+2)%3])
                    - 256'(a[(rr+1)%3][(cc+2)%3]) * 256'(a[(rr+2)%3][(cc+1)%3]);
      end
    det = 256'(a[0][0]) * cof[0][0] + 256'(a[0][1]) * cof[0][1]
        + 256'(a[0][2]) * cof[0][2];
    if (det == 0) begin
      r.user[m3i_pkg::USER_SINGULAR] = 1'b1;
      return r;
    end
    dmag = det < 0 ? -det : det;
    lim_hi = (256'sd1 <<< (EW-1)) - 1;
    lim_lo = -(256'sd1 <<< (EW-1));
    for (cc = 0; cc < 3; cc++)
      for (rr = 0; rr < 3; rr++) begin
        num = cof[cc][rr] <<< (2*FB);
        nmag = num < 0 ? -num : num;
        quo = nmag / dmag;
        res = ((num < 0) != (det < 0)) ? -quo : quo;
        if (res > lim_hi) begin res = lim_hi; sat = 1; end
        else if (res < lim_lo) begin res = lim_lo; sat = 1; end
        r.data[(cc*3+rr)*EW +: EW] = res[EW-1:0];
      end
    r.user[m3i_pkg::USER_SATURATED] = sat;
    return r;
  endfunction

  function void note_matrix(logic [DW-1:0] mat);
    pending.push_back(compute_inverse(mat));
  endfunction

  function void check_inverse(logic [DW-1:0] data, logic [m3i_pkg::USER_W-1:0] user);
    inverse_t exp_r;
    int k;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result data=%h user=%b", $time, data, user);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    for (k = 0; k < m3i_pkg::NUM_ELEMS; k++)
      if (data[k*EW +: EW] !== exp_r.data[k*EW +: EW]) begin
        $display("%0t: element %0d expected %h actual %h", $time, k,
                 exp_r.data[k*EW +: EW], data[k*EW +: EW]);
        errors++;
      end
    if (user !== exp_r.user) begin
      $display("%0t: flags expected %b actual %b", $time, exp_r.user, user);
      errors++;
    end
  endfunction
endclass

module matrix3_inverse_core_tb;
  localparam int EW = 32;
  localparam int DW = m3i_pkg::NUM_ELEMS * EW;
  localparam int RAND_ITEMS = 430;
  localparam int LATENCY = EW + 8;
  localparam int HOLD_CYCLES = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [DW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [DW-1:0] m_tdata;
  logic [m3i_pkg::USER_W-1:0] m_tuser;

  inverse_scoreboard sb = new();
  bit sending_done = 0;
  bit calm = 0;
  int hold_left = 0;
  bit hold_done = 0;

  matrix3_inverse_core dut (.*);

  always #2 clk = ~clk;

  function automatic logic [EW-1:0] rand_elem(int mode);
    case (mode)
      0: return $urandom();
      1: return EW'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      2: return EW'($signed($urandom_range(0, 4)) - 2) << 16;
      default: return EW'($signed($urandom_range(0, 1024)) - 512);
    endcase
  endfunction

  function automatic logic [DW-1:0] rand_matrix();
    logic [DW-1:0] m;
    int mode, k;
    mode = $urandom_range(0, 3);
    for (k = 0; k < 9; k++) m[k*EW +: EW] = rand_elem(mode);
    // make some singular by copying a column
    if ($urandom_range(0, 9) == 0) m[2*3*EW +: 3*EW] = m[0 +: 3*EW];
    return m;
  endfunction

  function automatic logic [DW-1:0] diag(logic [EW-1:0] d0, logic [EW-1:0] d1,
                                         logic [EW-1:0] d2);
    logic [DW-1:0] m;
    m = '0;
    m[0 +: EW] = d0;
    m[4*EW +: EW] = d1;
    m[8*EW +: EW] = d2;
    return m;
  endfunction

  task automatic send_matrix(logic [DW-1:0] mat);
    while (!calm && $urandom_range(0, 99) < 28) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= mat;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_matrix(mat);
    @(negedge clk);
  endtask

  // sample results at the rising edge
  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) sb.check_inverse(m_tdata, m_tuser);

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (!hold_done && sb.pending.size() > 20) begin
      hold_done <= 1;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else m_tready <= calm || $urandom_range(0, 99) >= 28;
  end

  initial begin
    logic [DW-1:0] m;
    int i;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    send_matrix('0);
    send_matrix({9{32'hFFFF_FFFF}});
    send_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_matrix(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_matrix(diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
    send_matrix(diag(32'hFFFF_0000, 32'h0002_0000, 32'h0000_8000));
    send_matrix(diag(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000));
    send_matrix({9{32'h5555_5555}});
    send_matrix({9{32'hAAAA_AAAA}});
    // swap first two rows of identity and negate the third: determinant is positive
    m = '0;
    m[1*EW +: EW] = 32'h0001_0000;
    m[3*EW +: EW] = 32'h0001_0000;
    m[8*EW +: EW] = 32'hFFFF_0000;
    send_matrix(m);
    // small determinant gives large outputs that still fit without saturation
    send_matrix(diag(32'h0000_0100, 32'h0000_0100, 32'h0000_0100));
    for (i = 0; i < 9; i++) begin
      m = '0;
      m[i*EW +: EW] = 32'hDEAD_BEEF;
      send_matrix(m);
    end
    for (i = 0; i < RAND_ITEMS; i++) begin
      calm = (i >= 200 && i < 260);
      send_matrix(rand_matrix());
    end
    calm = 0;
    s_tvalid <= 1'b0;
    sending_done = 1;
  end

  initial begin
    wait (sending_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end
endmodule

// ----- files.f -----
rtl/m3i_pkg.sv
rtl/matrix3_inverse_core.sv
tb/matrix3_inverse_core_tb.sv
